// File: hdl/sbfe_pkg.sv
// ----------------------------------------------------------------------------
// sbfe_pkg
// shared types and constants of the servo angle to servo bus frame encoder
// ----------------------------------------------------------------------------
package sbfe_pkg;

	// frame layout
	localparam int          FRAME_LEN    = 25;
	localparam int          CNT_W        = $clog2(FRAME_LEN);
	localparam logic [7:0]  FRAME_HEADER = 8'h0f;

	// channel scaling: value = (CENTER + angle * gain) / 100
	localparam logic signed [18:0] CENTER    = 19'sd102300;
	localparam logic signed [18:0] WING_GAIN = 19'sd1136;
	localparam logic signed [18:0] TAIL_GAIN = 19'sd1279;

	// reciprocal of 100, exact for 0 <= v < 2^18 with a shift of 25
	localparam logic [18:0] RECIP_100   = 19'd335545;
	localparam int          RECIP_SHIFT = 25;
	localparam int          CHAN_W      = 11;

	// scaled servo values before the divide by 100
	typedef struct packed {
		logic signed [18:0] left;
		logic signed [18:0] right;
		logic signed [18:0] tail_left;
		logic signed [18:0] tail_right;
	} scaled_t;

endpackage

// File: hdl/servo_angles_to_sbus_frame_top.sv
// ----------------------------------------------------------------------------
// servo_angles_to_sbus_frame_top
// turns wing, roll and pitch commands into 25-byte servo bus frames
// ----------------------------------------------------------------------------
// usage
//   slave side: one word per command, s_tdata = {pitch, roll, wing}, each a
//   signed 8-bit angle in degrees. master side: the 25 frame bytes of that
//   command in order, header first, m_tlast on the 25th byte.
//   glide_mode is written through glide_mode_we / glide_mode_wdata while the
//   block is idle; in glide mode the wing servos hold fixed angles.
// pipeline and throughput
//   the first byte of a frame is valid once its command word has passed the
//   command register, the scaling register and the framer's payload register;
//   the byte serializer sends one byte per cycle while m_tready is high. the next
//   command is taken while the current frame is being sent and its frame
//   follows with no gap, so one command per frame keeps the output saturated.
// reset
//   arst_n clears all valid flags and the byte counter and puts the block
//   in flapping mode; no frame is in flight after reset.
// stall
//   while m_tready is low the current byte holds; two commands queue in the
//   pipeline registers, then s_tready drops until the frame moves on.
// ----------------------------------------------------------------------------
module servo_angles_to_sbus_frame_top (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        glide_mode_we,
	input  logic        glide_mode_wdata,
	// command stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // wing_angle[7:0], roll_angle[15:8], pitch_angle[23:16]
	// frame byte stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // frame_byte[7:0]
	output logic        m_tlast    // last_byte
);
	import sbfe_pkg::*;

	logic    glide_mode_q;
	logic    map_valid;
	logic    map_ready;
	scaled_t map_scaled;

	// mode register; the user must write it only between commands, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			glide_mode_q <= 1'b0;
		end else if (glide_mode_we) begin
			glide_mode_q <= glide_mode_wdata;
		end
	end

	// command register, mixing and scaling to pre-divide channel values
	sbfe_mapper u_mapper (
		.clk         (clk),
		.arst_n      (arst_n),
		.glide_mode  (glide_mode_q),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.wing_angle  (s_tdata[7:0]),
		.roll_angle  (s_tdata[15:8]),
		.pitch_angle (s_tdata[23:16]),
		.out_valid   (map_valid),
		.out_ready   (map_ready),
		.out_scaled  (map_scaled)
	);

	// divide by 100, bit packing and byte serializer
	sbfe_framer u_framer (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (map_valid),
		.in_ready  (map_ready),
		.in_scaled (map_scaled),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule

// File: hdl/sbfe_mapper.sv
// ----------------------------------------------------------------------------
// sbfe_mapper
// input register, servo angle mixing, clamping and scaling register
// ----------------------------------------------------------------------------
module sbfe_mapper (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  glide_mode,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic signed [7:0]     wing_angle,
	input  logic signed [7:0]     roll_angle,
	input  logic signed [7:0]     pitch_angle,
	output logic                  out_valid,
	input  logic                  out_ready,
	output sbfe_pkg::scaled_t     out_scaled
);
	import sbfe_pkg::*;

	localparam logic signed [7:0] WING_LIMIT  = 8'sd90;
	localparam logic signed [7:0] TAIL_LIMIT  = 8'sd80;
	localparam logic signed [7:0] GLIDE_LEFT  = 8'sd25;
	localparam logic signed [7:0] GLIDE_RIGHT = -8'sd33;
	localparam logic signed [7:0] TAIL_TRIM   = 8'sd25;
	localparam logic signed [7:0] WING_OFFSET = 8'sd8;

	function automatic logic signed [7:0] clamp8(input logic signed [7:0] a,
			input logic signed [7:0] lim);
		if (a > lim) return lim;
		if (a < -lim) return -lim;
		return a;
	endfunction

	function automatic logic signed [18:0] scale(input logic signed [7:0] a,
			input logic signed [18:0] gain);
		return CENTER + 19'(a) * gain;
	endfunction

	logic              valid_s1;
	logic signed [7:0] wing_s1, roll_s1, pitch_s1;
	logic              valid_s2;
	scaled_t           scaled_s2;

	logic              adv_s2;
	logic signed [7:0] left, right, tail_left, tail_right;
	scaled_t           scaled;

	assign adv_s2   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv_s2;

	// 8-bit wrapping mix of the commands, then clamping and scaling
	always_comb begin
		if (glide_mode) begin
			left  = GLIDE_LEFT;
			right = GLIDE_RIGHT;
		end else begin
			left  = wing_s1 + roll_s1;
			right = roll_s1 - wing_s1 - WING_OFFSET;
		end
		tail_left  = pitch_s1 + TAIL_TRIM;
		tail_right = -tail_left;
		scaled.left       = scale(clamp8(left, WING_LIMIT), WING_GAIN);
		scaled.right      = scale(clamp8(right, WING_LIMIT), WING_GAIN);
		scaled.tail_left  = scale(clamp8(tail_left, TAIL_LIMIT), TAIL_GAIN);
		scaled.tail_right = scale(clamp8(tail_right, TAIL_LIMIT), TAIL_GAIN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) valid_s1 <= in_valid;
			if (!valid_s2 || out_ready) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			wing_s1  <= wing_angle;
			roll_s1  <= roll_angle;
			pitch_s1 <= pitch_angle;
		end
		if (adv_s2) scaled_s2 <= scaled;
	end

	assign out_valid  = valid_s2;
	assign out_scaled = scaled_s2;

endmodule

// File: hdl/sbfe_framer.sv
// ----------------------------------------------------------------------------
// sbfe_framer
// divide to channel values, pack the frame and send it one byte per word
// ----------------------------------------------------------------------------
module sbfe_framer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  sbfe_pkg::scaled_t in_scaled,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [7:0]        m_tdata,
	output logic              m_tlast
);
	import sbfe_pkg::*;

	localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(FRAME_LEN - 1);

	// floor(v / 100), negative values give zero
	function automatic logic [CHAN_W-1:0] to_channel(input logic signed [18:0] v);
		logic [36:0] prod;
		prod = 37'(v[17:0]) * 37'(RECIP_100);
		if (v[18]) return '0;
		return prod[RECIP_SHIFT +: CHAN_W];
	endfunction

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [47:0]      payload_q;

	logic             advance, last, load;
	logic [47:0]      payload;

	assign payload = {4'b0000,
		to_channel(in_scaled.tail_right), to_channel(in_scaled.tail_left),
		to_channel(in_scaled.right), to_channel(in_scaled.left)};

	assign last     = (cnt_q == LAST_IDX);
	assign advance  = busy_q && m_tready;
	assign in_ready = !busy_q || (advance && last);
	assign load     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (advance) begin
			if (last) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) payload_q <= payload;
	end

	always_comb begin
		case (cnt_q)
			CNT_W'(0): m_tdata = FRAME_HEADER;
			CNT_W'(1): m_tdata = payload_q[7:0];
			CNT_W'(2): m_tdata = payload_q[15:8];
			CNT_W'(3): m_tdata = payload_q[23:16];
			CNT_W'(4): m_tdata = payload_q[31:24];
			CNT_W'(5): m_tdata = payload_q[39:32];
			CNT_W'(6): m_tdata = payload_q[47:40];
			default:   m_tdata = 8'h00;
		endcase
	end

	assign m_tvalid = busy_q;
	assign m_tlast  = last;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> cnt_q <= LAST_IDX)
		else $error("byte index past end of frame");

	a_header_first: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && cnt_q == '0) |-> m_tdata == FRAME_HEADER)
		else $error("frame does not open with header");

	a_load_restart: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> busy_q && cnt_q == '0)
		else $error("new frame does not start at byte zero");

	a_step: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !last) |=> busy_q && cnt_q == $past(cnt_q) + 1'b1)
		else $error("byte index did not step after a word");

endmodule

// File: test/sbfe_frame_checker.sv
// ----------------------------------------------------------------------------
// sbfe_frame_checker
// predicts the 25-byte frame of every command word and checks the byte stream
// ----------------------------------------------------------------------------
module sbfe_frame_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        glide_mode_we,
	input  logic        glide_mode_wdata,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [23:0] s_tdata,   // wing_angle[7:0], roll_angle[15:8], pitch_angle[23:16]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,   // frame_byte[7:0]
	input  logic        m_tlast,   // last_byte
	output int          fail_count,
	output int          bytes_pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import sbfe_pkg::*;

	localparam int WING_LIMIT = 90;
	localparam int TAIL_LIMIT = 80;
	localparam int CHAN_BYTES = 6;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       last_byte;
	} frame_word_t;

	frame_word_t frame_bytes_due[$];
	logic        glide_shadow;
	int          mismatches;
	int          byte_pos;

	function automatic logic [CHAN_W-1:0] wing_servo_value(logic signed [7:0] angle);
		int a;
		a = angle;
		if (a > WING_LIMIT) a = WING_LIMIT;
		else if (a < -WING_LIMIT) a = -WING_LIMIT;
		return CHAN_W'((int'(CENTER) + a * int'(WING_GAIN)) / 100);
	endfunction

	function automatic logic [CHAN_W-1:0] tail_servo_value(logic signed [7:0] angle);
		int a;
		int v;
		a = angle;
		if (a > TAIL_LIMIT) a = TAIL_LIMIT;
		else if (a < -TAIL_LIMIT) a = -TAIL_LIMIT;
		v = int'(CENTER) + a * int'(TAIL_GAIN);
		if (v < 0) return '0;
		return CHAN_W'(v / 100);
	endfunction

	// all angle sums wrap at 8 bits, like the adders in the block
	task automatic predict_frame(logic [23:0] cmd, logic glide);
		logic signed [7:0] wing, roll, pitch;
		logic signed [7:0] left, right, tail_l, tail_r;
		logic [8*CHAN_BYTES-1:0] chans;
		frame_word_t w;
		wing  = cmd[7:0];
		roll  = cmd[15:8];
		pitch = cmd[23:16];
		if (glide) begin
			left  = 8'sd25;
			right = -8'sd33;
		end else begin
			left  = wing + roll;
			right = -(wing + 8'sd8 - roll);
		end
		tail_l = 8'sd25 + pitch;
		tail_r = -tail_l;
		chans = {4'b0000, tail_servo_value(tail_r), tail_servo_value(tail_l),
			wing_servo_value(right), wing_servo_value(left)};
		for (int k = 0; k < FRAME_LEN; k++) begin
			if (k == 0) w.frame_byte = FRAME_HEADER;
			else if (k <= CHAN_BYTES) w.frame_byte = chans[8*(k-1) +: 8];
			else w.frame_byte = 8'h00;
			w.last_byte = (k == FRAME_LEN - 1);
			frame_bytes_due.push_back(w);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		frame_word_t due;
		if (!arst_n) begin
			frame_bytes_due.delete();
			glide_shadow  <= 1'b0;
			mismatches    = 0;
			byte_pos      = 0;
			fail_count    <= 0;
			bytes_pending <= 0;
		end else begin
			// check before predicting so a byte can never match its own command
			if (m_tvalid && m_tready) begin
				if (frame_bytes_due.size() == 0) begin
					$error("frame byte %02h arrived with no frame pending", m_tdata);
					mismatches++;
				end else begin
					due = frame_bytes_due.pop_front();
					if (m_tdata !== due.frame_byte) begin
						$error("frame_byte mismatch at byte %0d: expected %02h, actual %02h",
							byte_pos, due.frame_byte, m_tdata);
						mismatches++;
					end
					if (m_tlast !== due.last_byte) begin
						$error("last_byte mismatch at byte %0d: expected %0b, actual %0b",
							byte_pos, due.last_byte, m_tlast);
						mismatches++;
					end
					byte_pos = due.last_byte ? 0 : byte_pos + 1;
				end
			end
			if (s_tvalid && s_tready)
				predict_frame(s_tdata, glide_shadow);
			if (glide_mode_we)
				glide_shadow <= glide_mode_wdata;
			fail_count    <= mismatches;
			bytes_pending <= frame_bytes_due.size();
		end
	end

endmodule

// File: test/tb_servo_angles_to_sbus_frame_top.sv
// ----------------------------------------------------------------------------
// tb_servo_angles_to_sbus_frame_top
// drives command words into the servo bus frame encoder and judges the run
// ----------------------------------------------------------------------------
// directed corner commands in both modes, then random phases that switch
// between flapping and glide mode; both stream sides pause at random while a
// separate frame checker predicts every byte and counts mismatches
// ----------------------------------------------------------------------------
module tb_servo_angles_to_sbus_frame_top;
	timeunit 1ns;
	timeprecision 1ps;
	import sbfe_pkg::*;

	// glide_mode register values
	localparam logic MODE_FLAP  = 1'b0;
	localparam logic MODE_GLIDE = 1'b1;

	// cycles with no word moving on either side before the run is abandoned
	localparam int IDLE_LIMIT     = 2000;
	// quiet cycles after the last byte, well past the pipeline latency
	localparam int SETTLE_CYCLES  = 8;
	localparam int RANDOM_PHASES  = 4;
	localparam int PHASE_COMMANDS = 110;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        glide_mode_we = 1'b0;
	logic        glide_mode_wdata = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        m_tlast;

	int   fail_count;
	int   bytes_pending;
	int   flap_commands = 0;
	int   glide_commands = 0;
	logic cur_mode = MODE_FLAP;
	// when low, neither side pauses: a stretch of back-to-back words
	logic idle_en = 1'b1;

	initial begin
		forever #5 clk = ~clk;
	end

	servo_angles_to_sbus_frame_top u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.glide_mode_we    (glide_mode_we),
		.glide_mode_wdata (glide_mode_wdata),
		.s_tvalid         (s_tvalid),
		.s_tready         (s_tready),
		.s_tdata          (s_tdata),
		.m_tvalid         (m_tvalid),
		.m_tready         (m_tready),
		.m_tdata          (m_tdata),
		.m_tlast          (m_tlast)
	);

	sbfe_frame_checker u_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.glide_mode_we    (glide_mode_we),
		.glide_mode_wdata (glide_mode_wdata),
		.s_tvalid         (s_tvalid),
		.s_tready         (s_tready),
		.s_tdata          (s_tdata),
		.m_tvalid         (m_tvalid),
		.m_tready         (m_tready),
		.m_tdata          (m_tdata),
		.m_tlast          (m_tlast),
		.fail_count       (fail_count),
		.bytes_pending    (bytes_pending)
	);

	// pause length: mostly none, often short, now and then a long one
	function automatic int idle_len();
		int r;
		if (!idle_en) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// full-range angles with a bias toward clamp edges and wrap points
	function automatic logic signed [7:0] pick_angle();
		if ($urandom_range(0, 9) < 7) return 8'($urandom_range(0, 255));
		case ($urandom_range(0, 11))
			0:       return -8'sd128;
			1:       return -8'sd91;
			2:       return -8'sd90;
			3:       return -8'sd80;
			4:       return -8'sd33;
			5:       return 8'sd0;
			6:       return 8'sd25;
			7:       return 8'sd55;
			8:       return 8'sd90;
			9:       return 8'sd91;
			10:      return 8'sd103;
			default: return 8'sd127;
		endcase
	endfunction

	// one command word; valid stays high across back-to-back words
	task automatic send_command(logic signed [7:0] wing, logic signed [7:0] roll,
		logic signed [7:0] pitch);
		int gap;
		gap = idle_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {pitch, roll, wing};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (cur_mode == MODE_GLIDE) glide_commands++;
		else flap_commands++;
	endtask

	// let every predicted byte come out, then SETTLE_CYCLES quiet cycles
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (bytes_pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// register write, only ever issued with the block idle
	task automatic set_mode(logic mode);
		glide_mode_we    <= 1'b1;
		glide_mode_wdata <= mode;
		@(posedge clk);
		glide_mode_we <= 1'b0;
		cur_mode = mode;
		@(posedge clk);
	endtask

	// frame byte receiver: runs of ready broken by random pauses
	initial begin
		int run;
		int gap;
		forever begin
			run = $urandom_range(1, 30);
			m_tready <= 1'b1;
			repeat (run) @(posedge clk);
			gap = idle_len();
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	// watchdog: a run of cycles where no word moves on either side
	initial begin
		int idle_run;
		idle_run = 0;
		while (idle_run < IDLE_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_run = 0;
			else idle_run++;
		end
		$display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// flapping mode corners
		set_mode(MODE_FLAP);
		send_command(8'sd0, 8'sd0, 8'sd0);
		// both wing sums wrap, tail sum wraps
		send_command(8'sd127, 8'sd127, 8'sd127);
		send_command(-8'sd128, -8'sd128, -8'sd128);
		send_command(8'sd127, -8'sd128, 8'sd0);
		send_command(-8'sd128, 8'sd127, 8'sd0);
		// right wing sum lands on -128, negation stays -128
		send_command(8'sd120, 8'sd0, 8'sd0);
		// exact clamp edges, wing +90 and tail +80
		send_command(8'sd90, 8'sd0, 8'sd55);
		send_command(8'sd91, 8'sd0, 8'sd56);
		// tail at -80: scaled value goes negative and saturates to zero
		send_command(-8'sd90, 8'sd0, -8'sd105);
		send_command(-8'sd91, 8'sd0, -8'sd106);
		// tail sum wraps to -128 and its negation stays -128
		send_command(8'sd0, 8'sd0, 8'sd103);
		send_command(8'sd0, 8'sd0, -8'sd25);
		send_command(8'sd64, -8'sd64, -8'sd128);
		send_command(8'sd1, 8'sd2, -8'sd1);
		drain();

		// glide mode: wing and roll have no effect
		set_mode(MODE_GLIDE);
		send_command(8'sd0, 8'sd0, 8'sd0);
		send_command(8'sd127, 8'sd127, 8'sd127);
		send_command(-8'sd128, -8'sd128, 8'sd103);
		send_command(8'sd55, -8'sd99, 8'sd55);
		send_command(-8'sd1, 8'sd1, -8'sd106);
		drain();

		// random phases alternate modes; the third runs without any pauses
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			idle_en = (phase != 2);
			set_mode((phase % 2) ? MODE_GLIDE : MODE_FLAP);
			repeat (PHASE_COMMANDS)
				send_command(pick_angle(), pick_angle(), pick_angle());
			drain();
		end

		$display("run: %0d flapping and %0d glide commands, %0d frame bytes predicted",
			flap_commands, glide_commands, (flap_commands + glide_commands) * FRAME_LEN);
		$display("run: wrap and clamp corners, random angles, both modes, random stalls");
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatches", fail_count);
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// File: servo_angles_to_sbus_frame_top.f
hdl/sbfe_pkg.sv
hdl/sbfe_mapper.sv
hdl/sbfe_framer.sv
hdl/servo_angles_to_sbus_frame_top.sv
test/sbfe_frame_checker.sv
test/tb_servo_angles_to_sbus_frame_top.sv
